// File: design/kwm_pkg.sv
// Package for the k-way merge min-heap: sizes, entry type, request codes, control structs.
package kwm_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int KEY_BITS    = 64;
  localparam int VALUE_BITS  = 32;

  localparam int KEY_PORT_W = 64;
  localparam int VAL_PORT_W = 32;
  localparam int SRC_W      = 4;
  localparam int CNT_PORT_W = 5;

  localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
  localparam int ADDR_W  = $clog2(MAX_SOURCES);
  localparam int ENTRY_W = KEY_BITS + VALUE_BITS + SRC_W;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_REPLACE = 2'd1,
    REQ_POP     = 2'd2,
    REQ_BAD     = 2'd3
  } req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [SRC_W-1:0]      source;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DN_L,
    ST_DN_R,
    ST_DN_MV,
    ST_HOLE_END,
    ST_PO_LD,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ld_req;
    logic err_set;
    logic cnt_inc;
    logic cnt_dec;
    logic i_init_ins;
    logic i_init_root;
    logic i_to_parent;
    logic i_to_cand;
    logic rd_root_left;
    logic rd_left;
    logic rd_right;
    logic rd_parent;
    logic rd_last;
    logic rd_cand_left;
    logic ld_cand_l;
    logic ld_cand_r;
    logic ld_ent_rd;
    logic wr_ent;
    logic wr_rd;
    logic wr_cand;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic empty;
    logic full;
    logic n_ge2;
    logic has_right;
    logic cand_has_left;
    logic ent_ge;
    logic right_lt;
    logic i_root;
    logic leaf_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = s - {{CNT_W{1'b0}}, 1'b1};
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic [CNT_PORT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+CNT_PORT_W-1:0] w;
    w = {{CNT_PORT_W{1'b0}}, c};
    return w[CNT_PORT_W-1:0];
  endfunction

endpackage

// File: design/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/kwm_dp.sv
// Datapath: heap RAM, slot pointers, sifting entry, fill count and result register.
module kwm_dp import kwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_req_type,
  input  logic [KEY_PORT_W-1:0] in_new_key,
  input  logic [VAL_PORT_W-1:0] in_new_value,
  input  logic [SRC_W-1:0]      in_new_source,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_PORT_W-1:0] out_top_key,
  output logic [VAL_PORT_W-1:0] out_top_value,
  output logic [SRC_W-1:0]      out_top_source,
  output logic                  out_top_valid,
  output logic [CNT_PORT_W-1:0] out_entry_count,
  output logic                  out_request_error,
  input  dp_cmd_t               cmd,
  output dp_stat_t              st
);

  req_t             req_r;
  entry_t           ent_r, cand_r, top_r;
  logic [CNT_W-1:0] cand_idx_r, i_r, cnt_r;
  logic             err_r;

  logic                  out_valid_r;
  logic [KEY_PORT_W-1:0] out_key_r;
  logic [VAL_PORT_W-1:0] out_val_r;
  logic [SRC_W-1:0]      out_src_r;
  logic                  out_tv_r;
  logic [CNT_PORT_W-1:0] out_cnt_r;
  logic                  out_err_r;

  logic [CNT_W:0]        lchild, rchild, cand_lchild, n_ext, rd_slot;
  logic [CNT_W-1:0]      parent;
  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [ENTRY_W-1:0]    rd_raw;
  entry_t                rd_ent, wr_ent, in_ent;
  logic [63:0]           val64;
  logic [63:0]           oval64;
  logic [KEY_PORT_W-1:0] okey;

  assign lchild      = {i_r, 1'b0};
  assign rchild      = {i_r, 1'b1};
  assign cand_lchild = {cand_idx_r, 1'b0};
  assign n_ext       = {1'b0, cnt_r};
  assign parent      = i_r >> 1;
  assign rd_ent      = rd_raw;

  assign val64         = {32'b0, in_new_value};
  assign in_ent.key    = in_new_key[KEY_BITS-1:0];
  assign in_ent.value  = val64[VALUE_BITS-1:0];
  assign in_ent.source = in_new_source;

  always_comb begin
    rd_en   = cmd.rd_root_left | cmd.rd_left | cmd.rd_right | cmd.rd_parent |
              cmd.rd_last | cmd.rd_cand_left;
    rd_slot = lchild;
    if (cmd.rd_root_left) begin
      rd_slot = (CNT_W+1)'(2);
    end else if (cmd.rd_right) begin
      rd_slot = rchild;
    end else if (cmd.rd_parent) begin
      rd_slot = {1'b0, parent};
    end else if (cmd.rd_last) begin
      rd_slot = n_ext;
    end else if (cmd.rd_cand_left) begin
      rd_slot = cand_lchild;
    end
    rd_addr = slot_addr(rd_slot);
  end

  always_comb begin
    wr_en   = cmd.wr_ent | cmd.wr_rd | cmd.wr_cand;
    wr_addr = slot_addr({1'b0, i_r});
    wr_ent  = ent_r;
    if (cmd.wr_rd) begin
      wr_ent = rd_ent;
    end else if (cmd.wr_cand) begin
      wr_ent = cand_r;
    end
  end

  kwm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SOURCES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r <= req_t'(in_req_type);
      ent_r <= in_ent;
    end else if (cmd.ld_ent_rd) begin
      ent_r <= rd_ent;
    end
    if (cmd.i_init_ins) begin
      i_r <= cnt_r + CNT_W'(1);
    end else if (cmd.i_init_root) begin
      i_r <= CNT_W'(1);
    end else if (cmd.i_to_parent) begin
      i_r <= parent;
    end else if (cmd.i_to_cand) begin
      i_r <= cand_idx_r;
    end
    if (cmd.ld_cand_l) begin
      cand_r     <= rd_ent;
      cand_idx_r <= lchild[CNT_W-1:0];
    end else if (cmd.ld_cand_r) begin
      cand_r     <= rd_ent;
      cand_idx_r <= rchild[CNT_W-1:0];
    end
    if (wr_en && i_r == CNT_W'(1)) begin
      top_r <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.ld_req) begin
        err_r <= 1'b0;
      end else if (cmd.err_set) begin
        err_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    okey   = '0;
    oval64 = '0;
    okey[KEY_BITS-1:0]     = top_r.key;
    oval64[VALUE_BITS-1:0] = top_r.value;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cnt_r != '0) begin
        out_key_r <= okey;
        out_val_r <= oval64[VAL_PORT_W-1:0];
        out_src_r <= top_r.source;
        out_tv_r  <= 1'b1;
      end else begin
        out_key_r <= '0;
        out_val_r <= '0;
        out_src_r <= '0;
        out_tv_r  <= 1'b0;
      end
      out_cnt_r <= cnt_out(cnt_r);
      out_err_r <= err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_top_key       = out_key_r;
  assign out_top_value     = out_val_r;
  assign out_top_source    = out_src_r;
  assign out_top_valid     = out_tv_r;
  assign out_entry_count   = out_cnt_r;
  assign out_request_error = out_err_r;

  assign st.req           = req_r;
  assign st.empty         = (cnt_r == '0);
  assign st.full          = (cnt_r >= CNT_W'(MAX_SOURCES));
  assign st.n_ge2         = (cnt_r >= CNT_W'(2));
  assign st.has_right     = (rchild <= n_ext);
  assign st.cand_has_left = (cand_lchild <= n_ext);
  assign st.ent_ge        = (ent_r.key >= rd_ent.key);
  assign st.right_lt      = (rd_ent.key < cand_r.key);
  assign st.i_root        = (i_r == CNT_W'(1));
  assign st.leaf_last     = (i_r == cnt_r);
  assign st.out_free      = !out_valid_r || out_ready;

endmodule

// File: design/kwm_ctrl.sv
// Controller: request sequencing for insert, replace and pop over the heap datapath.
module kwm_ctrl import kwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (st.req)
          REQ_INSERT: state_nxt = st.full ? ST_DONE : ST_UP_CHK;
          REQ_REPLACE, REQ_POP: begin
            if (st.empty) begin
              state_nxt = ST_DONE;
            end else if (st.n_ge2) begin
              state_nxt = ST_DN_L;
            end else begin
              state_nxt = ST_HOLE_END;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_DN_L: begin
        state_nxt = st.has_right ? ST_DN_R : ST_DN_MV;
      end
      ST_DN_R: begin
        state_nxt = ST_DN_MV;
      end
      ST_DN_MV: begin
        state_nxt = st.cand_has_left ? ST_DN_L : ST_HOLE_END;
      end
      ST_HOLE_END: begin
        if (st.req == REQ_REPLACE) begin
          state_nxt = ST_UP_CHK;
        end else if (st.leaf_last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PO_LD;
        end
      end
      ST_PO_LD: begin
        state_nxt = ST_UP_CHK;
      end
      ST_UP_CHK: begin
        state_nxt = st.i_root ? ST_DONE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_nxt = st.ent_ge ? ST_DONE : ST_UP_CHK;
      end
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_req = in_valid;
      end
      ST_DISPATCH: begin
        case (st.req)
          REQ_INSERT: begin
            cmd.err_set    = st.full;
            cmd.i_init_ins = !st.full;
            cmd.cnt_inc    = !st.full;
          end
          REQ_REPLACE, REQ_POP: begin
            cmd.err_set      = st.empty;
            cmd.i_init_root  = !st.empty;
            cmd.rd_root_left = !st.empty && st.n_ge2;
          end
          default: cmd.err_set = 1'b1;
        endcase
      end
      ST_DN_L: begin
        cmd.ld_cand_l = 1'b1;
        cmd.rd_right  = st.has_right;
      end
      ST_DN_R: begin
        cmd.ld_cand_r = st.right_lt;
      end
      ST_DN_MV: begin
        cmd.wr_cand      = 1'b1;
        cmd.i_to_cand    = 1'b1;
        cmd.rd_cand_left = st.cand_has_left;
      end
      ST_HOLE_END: begin
        if (st.req != REQ_REPLACE) begin
          cmd.cnt_dec = 1'b1;
          cmd.rd_last = !st.leaf_last;
        end
      end
      ST_PO_LD: begin
        cmd.ld_ent_rd = 1'b1;
      end
      ST_UP_CHK: begin
        cmd.wr_ent    = st.i_root;
        cmd.rd_parent = !st.i_root;
      end
      ST_UP_CMP: begin
        cmd.wr_ent      = st.ent_ge;
        cmd.wr_rd       = !st.ent_ge;
        cmd.i_to_parent = !st.ent_ge;
      end
      ST_DONE: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/kwm_merge_min_heap_top.sv
// Top level of the k-way merge min-heap: controller plus heap datapath.
// A binary min-heap of up to MAX_SOURCES entries (key, value tag, source)
// that takes one request at a time: insert, replace the top, or pop the top.
// Each request returns one result with the new top, the entry count and an
// error flag (insert when full, replace or pop when empty, unused code).
// The heap lives in a RAM with one read and one write port; each step down
// a level reads the left child, reads the right child if there is one and
// moves the smaller child up; each step up reads the parent and compares.
// A refused request goes straight to its result. The controller returns to
// idle before the next request is accepted, and a result that is not taken
// holds the controller until the output register frees. A new request is
// taken while the previous result waits in the output register.
module kway_merge_min_heap_top import kwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [KEY_PORT_W-1:0] in_new_key,
  input  logic [VAL_PORT_W-1:0] in_new_value,
  input  logic [SRC_W-1:0]      in_new_source,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_PORT_W-1:0] out_top_key,
  output logic [VAL_PORT_W-1:0] out_top_value,
  output logic [SRC_W-1:0]      out_top_source,
  output logic                  out_top_valid,
  output logic [CNT_PORT_W-1:0] out_entry_count,
  output logic                  out_request_error
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  kwm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  kwm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req_type),
    .in_new_key       (in_new_key),
    .in_new_value     (in_new_value),
    .in_new_source    (in_new_source),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_top_key      (out_top_key),
    .out_top_value    (out_top_value),
    .out_top_source   (out_top_source),
    .out_top_valid    (out_top_valid),
    .out_entry_count  (out_entry_count),
    .out_request_error(out_request_error),
    .cmd              (cmd),
    .st               (st)
  );

endmodule
